// ===== sv/ncc_pkg.sv =====
package ncc_pkg;

  // reference slots addressable on the configuration port
  localparam int REF_SLOTS      = 6;
  localparam int REF_PAIRS      = REF_SLOTS / 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int ID_BITS        = 3;
  localparam int LIMIT_BITS     = 10;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(15);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_REF_COLOR_0 = 3'd0,
    CFG_REF_COLOR_1 = 3'd1,
    CFG_REF_COLOR_2 = 3'd2,
    CFG_REF_COLOR_3 = 3'd3,
    CFG_REF_COLOR_4 = 3'd4,
    CFG_REF_COLOR_5 = 3'd5,
    CFG_MATCH_LIMIT = 3'd6,
    CFG_FALLBACK_ID = 3'd7
  } cfg_index_t;

endpackage

// ===== sv/ncc_if.sv =====
interface ncc_sample_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ncc_result_if
  import ncc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] color_id;
  logic               matched;

  modport source (output valid, output color_id, output matched, input ready);
  modport sink   (input valid, input color_id, input matched, output ready);
endinterface

// ===== sv/nearest_color_classifier.sv =====
// nearest colour classifier
// sample channel: one rgb sample per transfer (valid/ready), CHANNEL_BITS per colour.
// result channel: colour id of the nearest reference whose l1 distance is strictly
// below match_limit (lowest index on a tie), matched set; otherwise fallback_id with
// matched clear. exactly one result per sample, in order.
// configuration: cfg_write with cfg_index and cfg_data; indices 0 to 5 are the
// reference colours (red in the top channel), 6 is match_limit, 7 is fallback_id.
// write only while the pipeline is empty.
// pipeline: a sample passes four registered stages (abs differences, sum and limit
// compare, pair select, final select with output register) before its result is
// valid and can transfer.
// throughput: one sample per cycle while the result side keeps ready high.
// reset: empties the pipeline and holds sample ready low, references go to 0,
// match_limit to 15 and fallback_id to 0.
// stall: when result ready is low each stage holds its item; empty stages ahead
// still fill, and sample ready drops only once every stage is full. sample ready
// follows result ready through the stage chain in the same cycle.
module nearest_color_classifier
  import ncc_pkg::*;
#(
  parameter int NUM_REFS     = 6,
  parameter int CHANNEL_BITS = 8,
  localparam int CFG_BITS    = (3*CHANNEL_BITS > LIMIT_BITS) ? 3*CHANNEL_BITS : LIMIT_BITS,
  localparam int DIST_BITS   = CHANNEL_BITS + 2
) (
  input  logic                      clk,
  input  logic                      rst,
  ncc_sample_if.sink                sample,
  ncc_result_if.source              result,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  logic [NUM_REFS-1:0][3*CHANNEL_BITS-1:0] ref_color;
  logic [LIMIT_BITS-1:0]                   match_limit;
  logic [ID_BITS-1:0]                      fallback_id;

  logic                                    mid_valid;
  logic                                    mid_ready;
  logic [NUM_REFS-1:0][DIST_BITS-1:0]      mid_dist;
  logic [NUM_REFS-1:0]                     mid_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_color   <= '0;
      match_limit <= LIMIT_RESET;
      fallback_id <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_REF_COLOR_0, CFG_REF_COLOR_1, CFG_REF_COLOR_2,
        CFG_REF_COLOR_3, CFG_REF_COLOR_4, CFG_REF_COLOR_5: begin
          // slots beyond NUM_REFS are never compared, so they keep no storage
          for (int i = 0; i < NUM_REFS; i++) begin
            if (cfg_index == CFG_INDEX_BITS'(i)) ref_color[i] <= cfg_data[3*CHANNEL_BITS-1:0];
          end
        end
        CFG_MATCH_LIMIT: match_limit <= cfg_data[LIMIT_BITS-1:0];
        CFG_FALLBACK_ID: fallback_id <= cfg_data[ID_BITS-1:0];
      endcase
    end
  end

  ncc_dist #(
    .NUM_REFS     (NUM_REFS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .red         (sample.red),
    .green       (sample.green),
    .blue        (sample.blue),
    .ref_color   (ref_color),
    .match_limit (match_limit),
    .out_valid   (mid_valid),
    .out_ready   (mid_ready),
    .out_dist    (mid_dist),
    .out_hit     (mid_hit)
  );

  ncc_select #(
    .NUM_REFS  (NUM_REFS),
    .DIST_BITS (DIST_BITS)
  ) u_select (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .ref_dist    (mid_dist),
    .hit         (mid_hit),
    .fallback_id (fallback_id),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .color_id    (result.color_id),
    .matched     (result.matched)
  );

endmodule

// ===== sv/ncc_dist.sv =====
module ncc_dist
  import ncc_pkg::*;
#(
  parameter int NUM_REFS     = 6,
  parameter int CHANNEL_BITS = 8,
  localparam int DIST_BITS   = CHANNEL_BITS + 2,
  localparam int CMP_BITS    = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [CHANNEL_BITS-1:0]                    red,
  input  logic [CHANNEL_BITS-1:0]                    green,
  input  logic [CHANNEL_BITS-1:0]                    blue,
  input  logic [NUM_REFS-1:0][3*CHANNEL_BITS-1:0]    ref_color,
  input  logic [LIMIT_BITS-1:0]                      match_limit,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [NUM_REFS-1:0][DIST_BITS-1:0]         out_dist,
  output logic [NUM_REFS-1:0]                        out_hit
);

  logic                                          s1_valid;
  logic                                          s1_ready;
  logic [NUM_REFS-1:0][2:0][CHANNEL_BITS-1:0]    s1_diff;
  logic [NUM_REFS-1:0][2:0][CHANNEL_BITS-1:0]    s1_diff_next;

  logic                                          s2_valid;
  logic                                          s2_ready;
  logic [NUM_REFS-1:0][DIST_BITS-1:0]            s2_dist;
  logic [NUM_REFS-1:0][DIST_BITS-1:0]            s2_dist_next;
  logic [NUM_REFS-1:0]                           s2_hit;
  logic [NUM_REFS-1:0]                           s2_hit_next;

  // a stage takes new data when empty or when its content moves on
  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  // no transfer while reset is held
  assign in_ready = s1_ready && !rst;

  // stage 1: per channel absolute differences
  always_comb begin
    logic [2:0][CHANNEL_BITS-1:0] smp;
    logic [2:0][CHANNEL_BITS-1:0] rc;
    smp = {red, green, blue};
    for (int i = 0; i < NUM_REFS; i++) begin
      rc = ref_color[i];
      for (int c = 0; c < 3; c++) begin
        s1_diff_next[i][c] = (smp[c] > rc[c]) ? (smp[c] - rc[c]) : (rc[c] - smp[c]);
      end
    end
  end

  // stage 2: l1 sum and limit compare
  always_comb begin
    for (int i = 0; i < NUM_REFS; i++) begin
      s2_dist_next[i] = DIST_BITS'(s1_diff[i][0]) + DIST_BITS'(s1_diff[i][1])
                      + DIST_BITS'(s1_diff[i][2]);
      s2_hit_next[i]  = CMP_BITS'(s2_dist_next[i]) < CMP_BITS'(match_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1_diff <= s1_diff_next;
    if (s2_ready && s1_valid) begin
      s2_dist <= s2_dist_next;
      s2_hit  <= s2_hit_next;
    end
  end

  assign out_valid = s2_valid;
  assign out_dist  = s2_dist;
  assign out_hit   = s2_hit;

endmodule

// ===== sv/ncc_select.sv =====
module ncc_select
  import ncc_pkg::*;
#(
  parameter int NUM_REFS  = 6,
  parameter int DIST_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [NUM_REFS-1:0][DIST_BITS-1:0] ref_dist,
  input  logic [NUM_REFS-1:0]                hit,
  input  logic [ID_BITS-1:0]                 fallback_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ID_BITS-1:0]                 color_id,
  output logic                               matched
);

  logic [REF_SLOTS-1:0][DIST_BITS-1:0] pad_dist;
  logic [REF_SLOTS-1:0]                pad_hit;

  logic                                s3_valid;
  logic                                s3_ready;
  logic [REF_PAIRS-1:0]                s3_found;
  logic [REF_PAIRS-1:0]                s3_found_next;
  logic [REF_PAIRS-1:0][DIST_BITS-1:0] s3_dist;
  logic [REF_PAIRS-1:0][DIST_BITS-1:0] s3_dist_next;
  logic [REF_PAIRS-1:0][ID_BITS-1:0]   s3_id;
  logic [REF_PAIRS-1:0][ID_BITS-1:0]   s3_id_next;

  logic                                s4_ready;
  logic [ID_BITS-1:0]                  color_id_next;
  logic                                matched_next;

  // unused slots never qualify
  for (genvar i = 0; i < REF_SLOTS; i++) begin : g_pad
    if (i < NUM_REFS) begin : g_used
      assign pad_dist[i] = ref_dist[i];
      assign pad_hit[i]  = hit[i];
    end else begin : g_unused
      assign pad_dist[i] = '0;
      assign pad_hit[i]  = 1'b0;
    end
  end

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  // stage 3: pairwise winners, lower index kept on a tie
  always_comb begin
    logic take_lo;
    for (int p = 0; p < REF_PAIRS; p++) begin
      take_lo = pad_hit[2*p] && (!pad_hit[2*p+1] || pad_dist[2*p] <= pad_dist[2*p+1]);
      s3_found_next[p] = pad_hit[2*p] || pad_hit[2*p+1];
      s3_dist_next[p]  = take_lo ? pad_dist[2*p] : pad_dist[2*p+1];
      s3_id_next[p]    = take_lo ? ID_BITS'(2*p) : ID_BITS'(2*p+1);
    end
  end

  // stage 4: fold the pair winners in index order
  always_comb begin
    logic                 found;
    logic [DIST_BITS-1:0] best_dist;
    logic [ID_BITS-1:0]   best_id;
    found     = 1'b0;
    best_dist = '0;
    best_id   = '0;
    for (int p = 0; p < REF_PAIRS; p++) begin
      if (s3_found[p] && (!found || s3_dist[p] < best_dist)) begin
        found     = 1'b1;
        best_dist = s3_dist[p];
        best_id   = s3_id[p];
      end
    end
    matched_next  = found;
    color_id_next = found ? best_id : fallback_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_ready) s3_valid  <= in_valid;
      if (s4_ready) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_found <= s3_found_next;
      s3_dist  <= s3_dist_next;
      s3_id    <= s3_id_next;
    end
    if (s4_ready && s3_valid) begin
      color_id <= color_id_next;
      matched  <= matched_next;
    end
  end

endmodule

// ===== sv/ncc_checker.sv =====
module ncc_checker
  import ncc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ID_BITS-1:0] color_id,
  input logic               matched
);

  // a waiting result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_id) && $stable(matched))
    else $error("result changed or dropped while stalled");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a result only appears in an empty output after a matching earlier sample transfer
  assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready, 4))
    else $error("result without a matching sample transfer");

endmodule

bind nearest_color_classifier ncc_checker u_ncc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .color_id  (result.color_id),
  .matched   (result.matched)
);

// ===== tb/sv/tb.sv =====
module tb;
  import ncc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REFS     = 6;
  localparam int CHANNEL_BITS = 8;
  localparam int CFG_BITS     = 3 * CHANNEL_BITS;
  localparam int PIPE_DEPTH   = 4;
  localparam int LONG_HOLD    = 100;
  localparam int RANDOM_ITEMS = 1200;
  localparam int RANDOM_SETS  = 5;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [LIMIT_BITS-1:0]   dist_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } sample_t;

  typedef struct packed {
    logic [ID_BITS-1:0] color_id;
    logic               matched;
  } class_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  cfg_index_t          cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  ncc_sample_if #(.CHANNEL_BITS(CHANNEL_BITS)) sample_ch ();
  ncc_result_if                                result_ch ();

  nearest_color_classifier #(
    .NUM_REFS    (NUM_REFS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // register image used for prediction
  logic [CFG_BITS-1:0] ref_table [REF_SLOTS];
  dist_t               limit_reg;
  logic [ID_BITS-1:0]  fallback_reg;

  sample_t sample_queue [$];
  class_t  predicted_ids [$];
  sample_t next_sample;
  class_t  want;

  int  mismatches    = 0;
  int  src_gap       = 0;
  int  sink_gap      = 0;
  int  hold_left     = 0;
  bit  idle_on       = 1'b1;
  bit  pressure_arm  = 1'b0;
  bit  pressure_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[nearest_color_classifier] ERROR");
    $finish;
  end

  function automatic dist_t channel_gap(chan_t a, chan_t b);
    return (a > b) ? dist_t'(a - b) : dist_t'(b - a);
  endfunction

  function automatic class_t classify(chan_t r, chan_t g, chan_t b);
    class_t res;
    dist_t  gap_sum;
    dist_t  best;
    res.color_id = fallback_reg;
    res.matched  = 1'b0;
    best         = '0;
    for (int k = 0; k < NUM_REFS; k++) begin
      gap_sum = channel_gap(r, ref_table[k][3*CHANNEL_BITS-1:2*CHANNEL_BITS])
              + channel_gap(g, ref_table[k][2*CHANNEL_BITS-1:CHANNEL_BITS])
              + channel_gap(b, ref_table[k][CHANNEL_BITS-1:0]);
      // strict compare, first index kept on equal distance
      if (gap_sum < limit_reg && (!res.matched || gap_sum < best)) begin
        res.matched  = 1'b1;
        res.color_id = ID_BITS'(k);
        best         = gap_sum;
      end
    end
    return res;
  endfunction

  function automatic chan_t near_channel(chan_t c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > (1 << CHANNEL_BITS) - 1) v = (1 << CHANNEL_BITS) - 1;
    return chan_t'(v);
  endfunction

  task automatic set_reg(cfg_index_t idx, logic [CFG_BITS-1:0] value);
    case (idx)
      CFG_MATCH_LIMIT: limit_reg = value[LIMIT_BITS-1:0];
      CFG_FALLBACK_ID: fallback_reg = value[ID_BITS-1:0];
      default: ref_table[idx] = value;
    endcase
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_sample(chan_t r, chan_t g, chan_t b);
    sample_queue.push_back('{red: r, green: g, blue: b});
  endtask

  // wait until every queued sample has been classified and checked
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || sample_ch.valid || predicted_ids.size() != 0);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic random_config();
    logic [CFG_BITS-1:0] value;
    for (int k = 0; k < REF_SLOTS; k++) begin
      case ($urandom_range(0, 9))
        0: value = '0;
        1: value = '1;
        default: value = CFG_BITS'($urandom());
      endcase
      set_reg(cfg_index_t'(k), value);
    end
    case ($urandom_range(0, 5))
      0: value = CFG_BITS'($urandom_range(1, 64));
      1, 2: value = CFG_BITS'($urandom_range(64, 400));
      3: value = CFG_BITS'($urandom_range(0, (1 << LIMIT_BITS) - 1));
      4: value = CFG_BITS'(766);
      default: value = CFG_BITS'($urandom_range(20, 120));
    endcase
    // upper bits beyond the register width must be dropped
    value[CFG_BITS-1:LIMIT_BITS] = ($urandom_range(0, 1) == 0) ?
                                   '0 : (CFG_BITS-LIMIT_BITS)'($urandom());
    set_reg(CFG_MATCH_LIMIT, value);
    set_reg(CFG_FALLBACK_ID, CFG_BITS'($urandom()));
    close_writes();
  endtask

  task automatic random_samples(int count);
    int    pick;
    int    spread;
    chan_t r;
    chan_t g;
    chan_t b;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        pick   = $urandom_range(0, NUM_REFS - 1);
        spread = $urandom_range(0, 40);
        r = near_channel(ref_table[pick][3*CHANNEL_BITS-1:2*CHANNEL_BITS], spread);
        g = near_channel(ref_table[pick][2*CHANNEL_BITS-1:CHANNEL_BITS], spread);
        b = near_channel(ref_table[pick][CHANNEL_BITS-1:0], spread);
      end else begin
        r = chan_t'($urandom());
        g = chan_t'($urandom());
        b = chan_t'($urandom());
      end
      queue_sample(r, g, b);
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        sample_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 18) - 1;
        sample_ch.valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        next_sample = sample_queue.pop_front();
        sample_ch.valid <= 1'b1;
        sample_ch.red   <= next_sample.red;
        sample_ch.green <= next_sample.green;
        sample_ch.blue  <= next_sample.blue;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off to back the pipeline up
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (pressure_arm && !pressure_done) begin
        hold_left     = LONG_HOLD;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 18) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // predict on sample transfer, check on result transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        predicted_ids.push_back(classify(sample_ch.red, sample_ch.green, sample_ch.blue));
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_ids.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got id %0d matched %0b",
                   $time, result_ch.color_id, result_ch.matched);
        end else begin
          want = predicted_ids.pop_front();
          if (want.color_id !== result_ch.color_id || want.matched !== result_ch.matched) begin
            mismatches++;
            $display("%0t: mismatch, expected id %0d matched %0b, got id %0d matched %0b",
                     $time, want.color_id, want.matched,
                     result_ch.color_id, result_ch.matched);
          end
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = CFG_REF_COLOR_0;
    cfg_data        = '0;
    sample_ch.valid = 1'b0;
    sample_ch.red   = '0;
    sample_ch.green = '0;
    sample_ch.blue  = '0;
    result_ch.ready = 1'b0;
    for (int k = 0; k < REF_SLOTS; k++)
      ref_table[k] = '0;
    limit_reg    = LIMIT_RESET;
    fallback_reg = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values: all references black, limit 15
    queue_sample(8'h00, 8'h00, 8'h00);
    queue_sample(8'h05, 8'h05, 8'h04);
    queue_sample(8'h05, 8'h05, 8'h05);
    queue_sample(8'hFF, 8'hFF, 8'hFF);
    drain();

    // corners of the colour cube, limit at full scale with junk above it
    set_reg(CFG_REF_COLOR_0, 24'hFF0000);
    set_reg(CFG_REF_COLOR_1, 24'h00FF00);
    set_reg(CFG_REF_COLOR_2, 24'h0000FF);
    set_reg(CFG_REF_COLOR_3, 24'hFFFFFF);
    set_reg(CFG_REF_COLOR_4, 24'h000000);
    set_reg(CFG_REF_COLOR_5, 24'h808080);
    set_reg(CFG_MATCH_LIMIT, 24'hABC3FF);
    set_reg(CFG_FALLBACK_ID, 24'hFFFFF5);
    close_writes();
    queue_sample(8'hFF, 8'h00, 8'h00);
    queue_sample(8'h00, 8'hFF, 8'h00);
    queue_sample(8'h00, 8'h00, 8'hFF);
    queue_sample(8'hFF, 8'hFF, 8'hFF);
    queue_sample(8'h00, 8'h00, 8'h00);
    queue_sample(8'h80, 8'h80, 8'h80);
    queue_sample(8'h40, 8'h20, 8'h10);
    drain();

    // zero limit: nothing can match
    set_reg(CFG_MATCH_LIMIT, '0);
    close_writes();
    queue_sample(8'hFF, 8'h00, 8'h00);
    drain();

    // limit of one: exact hits only
    set_reg(CFG_MATCH_LIMIT, 24'd1);
    close_writes();
    queue_sample(8'hFF, 8'h00, 8'h00);
    queue_sample(8'hFF, 8'h00, 8'h01);
    drain();

    // two identical entries; distance from black is 288 for both
    set_reg(CFG_REF_COLOR_2, 24'h406080);
    set_reg(CFG_REF_COLOR_4, 24'h406080);
    set_reg(CFG_MATCH_LIMIT, 24'd288);
    close_writes();
    queue_sample(8'h00, 8'h00, 8'h00);
    drain();
    set_reg(CFG_MATCH_LIMIT, 24'd289);
    close_writes();
    queue_sample(8'h00, 8'h00, 8'h00);
    queue_sample(8'h41, 8'h60, 8'h80);
    drain();

    // just above the largest possible distance
    set_reg(CFG_MATCH_LIMIT, 24'd766);
    close_writes();
    queue_sample(8'h00, 8'h00, 8'h00);
    drain();

    for (int p = 0; p < RANDOM_SETS; p++) begin
      random_config();
      if (p == 1)
        pressure_arm = 1'b1;
      if (p == RANDOM_SETS - 1)
        idle_on = 1'b0;
      random_samples(RANDOM_ITEMS / RANDOM_SETS);
      drain();
    end

    if (mismatches == 0)
      $display("[nearest_color_classifier] OK");
    else
      $display("[nearest_color_classifier] ERROR");
    $finish;
  end

endmodule
